// File: hw/rtl/ook_temperature_frame_transmitter_macros.svh
// ----------------------------------------------------------------------------
// ook_temperature_frame_transmitter_macros.svh
// assertion helpers included by the transmitter top module
// ----------------------------------------------------------------------------
`ifndef OOK_TEMPERATURE_FRAME_TRANSMITTER_MACROS_SVH
`define OOK_TEMPERATURE_FRAME_TRANSMITTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define OOKTX_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define OOKTX_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ooktx_pkg.sv
// ----------------------------------------------------------------------------
// ooktx_pkg
// shared types and constants of the ook temperature frame transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package ooktx_pkg;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned FrameW = 32;

  // register indexes on the config port
  typedef enum logic [2:0] {
    REG_DEVICE_CODE  = 3'd0,
    REG_REPEAT_COUNT = 3'd1,
    REG_SYNC_TIME    = 3'd2,
    REG_LONG_TIME    = 3'd3,
    REG_SHORT_TIME   = 3'd4
  } cfg_reg_e;

  localparam logic [7:0]  RepeatCountRst = 8'd15;
  localparam logic [15:0] SyncTimeRst    = 16'd1000;
  localparam logic [15:0] LongTimeRst    = 16'd490;
  localparam logic [15:0] ShortTimeRst   = 16'd160;

  // decoded word kinds
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_BURST = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [FrameW-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  device_code;
    logic [7:0]  repeat_count;
    logic [15:0] sync_time;
    logic [15:0] long_time;
    logic [15:0] short_time;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/ook_temperature_frame_transmitter.sv
// ----------------------------------------------------------------------------
// ook_temperature_frame_transmitter
// on-off-keyed temperature frame transmitter, one word per microsecond tick
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o mode_i, temp_tenths_i
//   out      output     out_valid_o/out_stall_i line_level_o, busy_res_o,
//                                               done_res_o, rejected_o
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// one word per cycle sustained while out_stall_i stays low; a word accepted
// on the input passes through a queue slot and then the sequencer's output
// register before it shows up on the outputs
// the queue holds two words; in_stall_o rises only when both are taken
// reset is asynchronous, active low; the line starts idle with registers
// at their defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module ook_temperature_frame_transmitter import ooktx_pkg::*; #(
  parameter int unsigned REGISTER_BURSTS = 4,
  parameter int unsigned SYNC_PAIRS      = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // config write port
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  // input words
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [12:0]      temp_tenths_i,
  // result words
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  line_level_o,
  output logic                  busy_res_o,
  output logic                  done_res_o,
  output logic                  rejected_o
);

`include "ook_temperature_frame_transmitter_macros.svh"

  // config registers
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEVICE_CODE:  cfg_d.device_code  = cfg_wdata_i[7:0];
        REG_REPEAT_COUNT: cfg_d.repeat_count = cfg_wdata_i[7:0];
        REG_SYNC_TIME:    cfg_d.sync_time    = cfg_wdata_i;
        REG_LONG_TIME:    cfg_d.long_time    = cfg_wdata_i;
        REG_SHORT_TIME:   cfg_d.short_time   = cfg_wdata_i;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_code  <= '0;
      cfg_q.repeat_count <= RepeatCountRst;
      cfg_q.sync_time    <= SyncTimeRst;
      cfg_q.long_time    <= LongTimeRst;
      cfg_q.short_time   <= ShortTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: decode the word and build the frame for start and burst words
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full, q_nonempty, q_pop, q_push;

  ooktx_front u_front (
    .cfg_i         (cfg_q),
    .mode_i        (mode_i),
    .temp_tenths_i (temp_tenths_i),
    .cmd_o         (front_cmd)
  );

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  // decouples the input side from output stalls
  ooktx_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .pop_i      (q_pop),
    .head_o     (head_cmd)
  );

  // back: symbol timing and line level
  ooktx_back #(
    .SYNC_PAIRS      (SYNC_PAIRS),
    .REGISTER_BURSTS (REGISTER_BURSTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (q_nonempty),
    .cmd_i        (head_cmd),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_level_o (line_level_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .rejected_o   (rejected_o)
  );

  // the ending tick is sent while busy at the high level
  `OOKTX_ASSERT_IMP(a_done_high, clk_i, rst_ni, out_valid_o && done_res_o,
    busy_res_o && line_level_o && !rejected_o, "done word not busy and high")
  // an idle line stays low
  `OOKTX_ASSERT_IMP(a_idle_low, clk_i, rst_ni, out_valid_o && !busy_res_o,
    !line_level_o && !done_res_o && !rejected_o, "idle word not all low")
  // a full queue with no pop stays full and keeps stalling the input
  `OOKTX_ASSERT_NXT(a_queue_hold, clk_i, rst_ni, q_full && !q_pop,
    q_full && in_stall_o, "queue lost a word while full")

endmodule

`default_nettype wire

// File: hw/rtl/ooktx_front.sv
// ----------------------------------------------------------------------------
// ooktx_front
// classifies incoming words and builds the frame for start and burst words
// ----------------------------------------------------------------------------
`default_nettype none

module ooktx_front import ooktx_pkg::*; (
  input  var cfg_t        cfg_i,
  input  wire logic [1:0] mode_i,
  input  wire logic [12:0] temp_tenths_i,
  output cmd_t            cmd_o
);

  localparam logic signed [13:0] TempOffset  = 14'sd500;
  localparam logic [12:0]        BurstTenths = 13'd100;
  localparam logic [7:0]         ChkSeed     = 8'h66;
  localparam logic [7:0]         Byte2Base   = 8'h90;

  function automatic logic [7:0] swap_nib(input logic [7:0] b);
    swap_nib = {b[3:0], b[7:4]};
  endfunction

  logic [12:0]        tenths;
  logic signed [13:0] sum;
  logic [11:0]        val;
  logic [7:0]         b3, b2, b1, b0, chk;

  always_comb begin
    tenths = (mode_i == CMD_BURST) ? BurstTenths : temp_tenths_i;
    sum    = $signed({tenths[12], tenths}) + TempOffset;
    // clamp to 0..4095
    if (sum[13]) begin
      val = '0;
    end else if (sum[12]) begin
      val = '1;
    end else begin
      val = sum[11:0];
    end
    b3  = cfg_i.device_code;
    b2  = Byte2Base + {4'd0, val[11:8]};
    b1  = val[7:0];
    chk = ChkSeed + swap_nib(b1) + swap_nib(b2) + swap_nib(b3);
    b0  = swap_nib(chk);
    cmd_o.kind  = cmd_e'(mode_i);
    cmd_o.frame = {b3, b2, b1, b0};
  end

endmodule

`default_nettype wire

// File: hw/rtl/ooktx_queue.sv
// ----------------------------------------------------------------------------
// ooktx_queue
// two-entry queue between the decode front and the line sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module ooktx_queue import ooktx_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  var cmd_t  push_cmd_i,
  output logic      full_o,
  output logic      nonempty_o,
  input  wire logic pop_i,
  output cmd_t      head_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign full_o     = count_q[1];
  assign nonempty_o = (count_q != 2'd0);
  assign head_o     = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: hw/rtl/ooktx_back.sv
// ----------------------------------------------------------------------------
// ooktx_back
// line sequencer: runs sync pairs and data bits; unless the output stalls, one word per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ooktx_back import ooktx_pkg::*; #(
  parameter int unsigned SYNC_PAIRS      = 5,
  parameter int unsigned REGISTER_BURSTS = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  var cfg_t  cfg_i,
  input  wire logic cmd_valid_i,
  input  var cmd_t  cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic      line_level_o,
  output logic      busy_res_o,
  output logic      done_res_o,
  output logic      rejected_o
);

  localparam int unsigned SymEnd = SYNC_PAIRS + FrameW;
  localparam int unsigned SymW   = $clog2(SymEnd + 1);
  localparam int unsigned BurstW = $clog2(REGISTER_BURSTS + 1);

  function automatic logic [15:0] min_one16(input logic [15:0] x);
    min_one16 = (x == 16'd0) ? 16'd1 : x;
  endfunction

  function automatic logic [7:0] min_one8(input logic [7:0] x);
    min_one8 = (x == 8'd0) ? 8'd1 : x;
  endfunction

  logic [FrameW-1:0] frame_q, frame_d;
  logic [7:0]        repeats_q, repeats_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic              high_q, high_d;
  logic [15:0]       ticks_q, ticks_d;
  logic [BurstW-1:0] bursts_q, bursts_d;
  logic              active_q, active_d;

  logic out_valid_q, out_valid_d;
  logic level_q, level_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic rej_q, rej_d;

  logic              fire;
  logic [SymW-1:0]   sym_inc, next_sym, eval_sym, idx_full;
  logic              eval_high, eval_bit;
  logic [15:0]       eval_ticks, tdec;
  logic [7:0]        rep_dec;

  assign fire  = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  always_comb begin
    sym_inc  = sym_q + SymW'(1);
    next_sym = (sym_inc >= SymW'(SymEnd)) ? '0 : sym_inc;
    // one duration lookup serves both the low-to-high and high-to-low edges
    eval_sym  = high_q ? next_sym : sym_q;
    eval_high = ~high_q;
    idx_full  = SymW'(SYNC_PAIRS + FrameW - 1) - eval_sym;
    eval_bit  = frame_q[idx_full[4:0]];
    if (eval_sym < SymW'(SYNC_PAIRS)) begin
      eval_ticks = min_one16(cfg_i.sync_time);
    end else if (eval_bit != eval_high) begin
      eval_ticks = min_one16(cfg_i.long_time);
    end else begin
      eval_ticks = min_one16(cfg_i.short_time);
    end
    tdec    = ticks_q - 16'd1;
    rep_dec = repeats_q - 8'd1;
  end

  always_comb begin
    frame_d   = frame_q;
    repeats_d = repeats_q;
    sym_d     = sym_q;
    high_d    = high_q;
    ticks_d   = ticks_q;
    bursts_d  = bursts_q;
    active_d  = active_q;
    level_d   = active_q && high_q;
    busy_d    = active_q;
    done_d    = 1'b0;
    rej_d     = 1'b0;
    unique case (cmd_i.kind)
      CMD_START, CMD_BURST: begin
        if (active_q) begin
          rej_d = 1'b1;
        end else begin
          frame_d   = cmd_i.frame;
          repeats_d = min_one8(cfg_i.repeat_count);
          bursts_d  = (cmd_i.kind == CMD_BURST) ? BurstW'(REGISTER_BURSTS - 1) : '0;
          sym_d     = '0;
          high_d    = 1'b0;
          ticks_d   = min_one16(cfg_i.sync_time);
          active_d  = 1'b1;
          busy_d    = 1'b1;
        end
      end
      CMD_TICK: begin
        if (active_q) begin
          if (tdec != 16'd0) begin
            ticks_d = tdec;
          end else if (!high_q) begin
            high_d  = 1'b1;
            ticks_d = eval_ticks;
          end else begin
            high_d  = 1'b0;
            sym_d   = next_sym;
            ticks_d = eval_ticks;
            if (sym_inc >= SymW'(SymEnd)) begin
              if (rep_dec != 8'd0) begin
                repeats_d = rep_dec;
              end else if (bursts_q != '0) begin
                bursts_d  = bursts_q - BurstW'(1);
                repeats_d = min_one8(cfg_i.repeat_count);
              end else begin
                repeats_d = rep_dec;
                active_d  = 1'b0;
                done_d    = 1'b1;
              end
            end
          end
        end
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeats_q   <= '0;
      sym_q       <= '0;
      high_q      <= 1'b0;
      ticks_q     <= '0;
      bursts_q    <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        repeats_q <= repeats_d;
        sym_q     <= sym_d;
        high_q    <= high_d;
        ticks_q   <= ticks_d;
        bursts_q  <= bursts_d;
        active_q  <= active_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      frame_q <= frame_d;
      level_q <= level_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      rej_q   <= rej_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = level_q;
  assign busy_res_o   = busy_q;
  assign done_res_o   = done_q;
  assign rejected_o   = rej_q;

endmodule

`default_nettype wire

// File: sim/tb_ook_temperature_frame_transmitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ook_temperature_frame_transmitter
// self-checking bench for the on-off-keyed temperature frame transmitter
//
// every accepted word goes through a bit-true tracker of the line sequencer;
// each result word is checked field by field against the oldest prediction.
// a directed part covers temperature boundaries, busy probes and a register
// burst, then random phases change the registers while idle and send frames
// with tick noise, busy starts and nops, under random sender gaps and
// receiver stalls, until the word target is reached
// ----------------------------------------------------------------------------

module tb_ook_temperature_frame_transmitter;
  import ooktx_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int REGISTER_BURSTS = 4;
  localparam int SYNC_PAIRS      = 5;
  localparam int TEMP_OFFSET     = 500;    // tenths added before framing
  localparam int VALUE_MAX       = 4095;   // 12-bit saturation ceiling
  localparam int BURST_TENTHS    = 100;    // register burst sends 10.0 degrees
  localparam logic [7:0] NIBBLE_TAG = 8'h90;
  localparam logic [7:0] CSUM_BIAS  = 8'h66;
  localparam int WORD_TARGET     = 1000;   // random phases stop past this many words
  localparam int STUCK_LIMIT     = 2000;   // cycles with no handshake at all
  localparam int DRAIN_CYCLES    = 4;      // output register plus queue slot

  typedef struct packed {
    logic level;
    logic busy;
    logic done;
    logic rej;
  } tx_word_t;

  // tracks the line sequencer and holds the result words still due
  class ook_line_tracker;
    logic [7:0]  dev_code;
    logic [7:0]  rep_count;
    logic [15:0] sync_len;
    logic [15:0] long_len;
    logic [15:0] short_len;

    logic [31:0] tx_frame;
    logic [7:0]  repeats_to_go;
    logic [5:0]  symbol;
    logic        in_high;
    logic [15:0] half_ticks_left;
    logic [2:0]  frames_to_go;
    logic        sending;

    tx_word_t    line_words_due[$];
    int          n_checked;
    int          n_errors;
    int          n_done;
    int          n_rejected;

    function new();
      dev_code        = 8'h00;
      rep_count       = RepeatCountRst;
      sync_len        = SyncTimeRst;
      long_len        = LongTimeRst;
      short_len       = ShortTimeRst;
      tx_frame        = '0;
      repeats_to_go   = '0;
      symbol          = '0;
      in_high         = 1'b0;
      half_ticks_left = '0;
      frames_to_go    = '0;
      sending         = 1'b0;
      n_checked       = 0;
      n_errors        = 0;
      n_done          = 0;
      n_rejected      = 0;
    endfunction

    function void write_reg(cfg_reg_e r, logic [15:0] v);
      case (r)
        REG_DEVICE_CODE:  dev_code  = v[7:0];
        REG_REPEAT_COUNT: rep_count = v[7:0];
        REG_SYNC_TIME:    sync_len  = v;
        REG_LONG_TIME:    long_len  = v;
        REG_SHORT_TIME:   short_len = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] swap_nib(logic [7:0] b);
      return {b[3:0], b[7:4]};
    endfunction

    // zero durations and a zero repeat count act as one
    function logic [15:0] at_least_one(logic [15:0] x);
      return (x == 16'd0) ? 16'd1 : x;
    endfunction

    // length of one half: sync halves are fixed, data halves depend on the bit
    function logic [15:0] half_len(logic [5:0] sym, logic hi);
      logic data_bit;
      if (sym < SYNC_PAIRS) return at_least_one(sync_len);
      data_bit = tx_frame[31 - (int'(sym) - SYNC_PAIRS)];
      return (data_bit != hi) ? at_least_one(long_len) : at_least_one(short_len);
    endfunction

    function bit idle();
      return !sending;
    endfunction

    function int pending();
      return line_words_due.size();
    endfunction

    function void note_word(cmd_e kind, logic [12:0] temp);
      tx_word_t   want;
      int         value;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [7:0] total;
      want.level = sending ? in_high : 1'b0;
      want.busy  = sending;
      want.done  = 1'b0;
      want.rej   = 1'b0;
      case (kind)
        CMD_START, CMD_BURST: begin
          if (sending) begin
            want.rej = 1'b1;
            n_rejected++;
          end else begin
            value = ((kind == CMD_START) ? int'($signed(temp)) : BURST_TENTHS) + TEMP_OFFSET;
            if (value < 0) value = 0;
            if (value > VALUE_MAX) value = VALUE_MAX;
            b3 = dev_code;
            b2 = NIBBLE_TAG + {4'h0, value[11:8]};
            b1 = value[7:0];
            total = CSUM_BIAS + swap_nib(b1) + swap_nib(b2) + swap_nib(b3);
            tx_frame        = {b3, b2, b1, swap_nib(total)};
            repeats_to_go   = 8'(at_least_one({8'h00, rep_count}));
            frames_to_go    = (kind == CMD_BURST) ? 3'(REGISTER_BURSTS - 1) : 3'd0;
            symbol          = '0;
            in_high         = 1'b0;
            sending         = 1'b1;
            half_ticks_left = half_len(6'd0, 1'b0);
            want.level      = 1'b0;
            want.busy       = 1'b1;
          end
        end
        CMD_TICK: begin
          if (sending) begin
            half_ticks_left = half_ticks_left - 16'd1;
            if (half_ticks_left == 16'd0) begin
              if (!in_high) begin
                in_high         = 1'b1;
                half_ticks_left = half_len(symbol, 1'b1);
              end else begin
                in_high = 1'b0;
                symbol  = symbol + 6'd1;
                if (symbol >= SYNC_PAIRS + FrameW) begin
                  symbol        = '0;
                  repeats_to_go = repeats_to_go - 8'd1;
                  if (repeats_to_go == 8'd0) begin
                    if (frames_to_go != 3'd0) begin
                      frames_to_go  = frames_to_go - 3'd1;
                      repeats_to_go = 8'(at_least_one({8'h00, rep_count}));
                    end else begin
                      sending   = 1'b0;
                      want.done = 1'b1;
                      n_done++;
                    end
                  end
                end
                if (sending) half_ticks_left = half_len(symbol, 1'b0);
              end
            end
          end
        end
        default: ;
      endcase
      line_words_due.push_back(want);
    endfunction

    function void check_word(tx_word_t got);
      tx_word_t want;
      string    field_name [4];
      field_name = '{"rejected", "done", "busy", "level"};
      if (line_words_due.size() == 0) begin
        $display("%0t: result word with nothing due, got level=%b busy=%b done=%b rejected=%b",
                 $time, got.level, got.busy, got.done, got.rej);
        n_errors++;
        return;
      end
      want = line_words_due.pop_front();
      n_checked++;
      for (int i = 3; i >= 0; i--) begin
        if (got[i] !== want[i]) begin
          $display("%0t: %s mismatch on result %0d, expected %b, got %b",
                   $time, field_name[i], n_checked, want[i], got[i]);
          n_errors++;
        end
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [2:0]  cfg_idx     = '0;
  logic [15:0] cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic [1:0]  mode        = CMD_TICK;
  logic [12:0] temp_tenths = '0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        line_level;
  logic        busy_res;
  logic        done_res;
  logic        rejected;

  ook_line_tracker tracker = new();

  bit idle_en   = 1'b0;   // sender gaps between bursts
  bit stall_en  = 1'b0;   // receiver stall pattern
  int run_left  = 0;      // words left in the current sender burst
  int stall_cnt = 0;
  int stuck     = 0;
  int n_words   = 0;
  int n_in      = 0;

  ook_temperature_frame_transmitter #(
    .REGISTER_BURSTS(REGISTER_BURSTS),
    .SYNC_PAIRS     (SYNC_PAIRS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .temp_tenths_i(temp_tenths),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .line_level_o (line_level),
    .busy_res_o   (busy_res),
    .done_res_o   (done_res),
    .rejected_o   (rejected)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: runs of random length, each one stalled or flowing at random
  always @(posedge clk) begin
    if (!stall_en) begin
      out_stall <= 1'b0;
    end else if (stall_cnt == 0) begin
      stall_cnt <= $urandom_range(1, 24);
      out_stall <= ($urandom_range(0, 2) == 0);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
  end

  // result check and watchdog, sampled on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_word({line_level, busy_res, done_res, rejected});
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck == STUCK_LIMIT) begin
          $display("%0t: no handshake for %0d cycles, %0d results still due",
                   $time, STUCK_LIMIT, tracker.pending());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  function automatic logic [12:0] rand_temp();
    int t;
    // mostly the legal sensor range, sometimes any 13-bit pattern
    if ($urandom_range(0, 4) == 0) t = $urandom_range(0, 8191);
    else t = int'($urandom_range(0, 4095)) - TEMP_OFFSET;
    return t[12:0];
  endfunction

  // one word on the input channel, held until accepted
  task automatic send_word(cmd_e kind, logic [12:0] temp);
    if (idle_en && run_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      run_left = $urandom_range(1, 40);
    end
    if (run_left > 0) run_left--;
    in_valid    <= 1'b1;
    mode        <= kind;
    temp_tenths <= temp;
    do @(posedge clk); while (in_stall);
    tracker.note_word(kind, temp);
    n_in++;
    if (kind != CMD_NOP) n_words++;
  endtask

  // ticks until the transmission ends, with busy starts and nops mixed in
  task automatic drain(int noise_pct);
    while (!tracker.idle()) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       send_word(CMD_START, rand_temp());
          1:       send_word(CMD_BURST, rand_temp());
          default: send_word(CMD_NOP, rand_temp());
        endcase
      end else begin
        send_word(CMD_TICK, rand_temp());
      end
    end
  endtask

  // directed busy probes: nop and both starts land in the first high half
  task automatic probe_busy_then_drain();
    send_word(CMD_TICK, 13'h0000);
    send_word(CMD_NOP, 13'h1FFF);
    send_word(CMD_START, 13'h0123);
    send_word(CMD_BURST, 13'h1FFF);
    drain(0);
  endtask

  // wait for every due result, so the block is idle for register writes
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // write all five registers, one per cycle
  task automatic load_regs(logic [7:0] dev, logic [7:0] rep, logic [15:0] sync_t,
                           logic [15:0] long_t, logic [15:0] short_t);
    logic [15:0] v [5];
    v[REG_DEVICE_CODE]  = {8'h00, dev};
    v[REG_REPEAT_COUNT] = {8'h00, rep};
    v[REG_SYNC_TIME]    = sync_t;
    v[REG_LONG_TIME]    = long_t;
    v[REG_SHORT_TIME]   = short_t;
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= 3'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      tracker.write_reg(cfg_reg_e'(i), v[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0]  dev_pick;
    logic [15:0] sync_pick;
    logic [15:0] long_pick;
    logic [15:0] short_pick;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: shortest legal timing, zero repeat and zero durations
    load_regs(8'hFF, 8'd0, 16'd0, 16'd2, 16'd0);
    send_word(CMD_TICK, 13'h1FFF);
    send_word(CMD_NOP, 13'h0AAA);
    send_word(CMD_START, -13'sd501);        // one below the floor
    probe_busy_then_drain();
    send_word(CMD_START, -13'sd500);        // exactly zero after offset
    probe_busy_then_drain();
    send_word(CMD_START, 13'd3595);         // exactly 4095 after offset
    probe_busy_then_drain();
    send_word(CMD_START, 13'd3596);         // one above the ceiling
    probe_busy_then_drain();
    send_word(CMD_BURST, 13'h1555);         // register burst ignores the field
    probe_busy_then_drain();
    send_word(CMD_NOP, 13'h1555);

    // random phases: new registers while idle, then one or two transmissions
    while (n_in < WORD_TARGET) begin
      settle();
      dev_pick = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) dev_pick = 8'h00;
      else if ($urandom_range(0, 4) == 0) dev_pick = 8'hFF;
      sync_pick  = 16'($urandom_range(0, 3));
      long_pick  = 16'($urandom_range(0, 4));
      short_pick = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) begin
        sync_pick  = 16'($urandom_range(0, 10));
        long_pick  = 16'($urandom_range(0, 10));
        short_pick = 16'($urandom_range(0, 10));
      end
      load_regs(dev_pick, 8'($urandom_range(0, 2)), sync_pick, long_pick, short_pick);
      idle_en  = ($urandom_range(0, 3) != 0);
      stall_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 2)) begin
        send_word(($urandom_range(0, 3) == 0) ? CMD_BURST : CMD_START, rand_temp());
        drain($urandom_range(0, 15));
        repeat ($urandom_range(0, 2))
          send_word(($urandom_range(0, 1) == 0) ? CMD_TICK : CMD_NOP, rand_temp());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d words in (%0d not nops), %0d results checked",
             n_in, n_words, tracker.n_checked);
    $display("%0d transmissions ended, %0d busy starts",
             tracker.n_done, tracker.n_rejected);
    if (tracker.n_errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results still due", tracker.n_errors, tracker.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
